/* rtl/tilt_fall_direction_detector_defines.svh */
// ----------------------------------------------------------------------------
// Tilt fall direction detector: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TILT_FALL_DIRECTION_DETECTOR_DEFINES_SVH
`define TILT_FALL_DIRECTION_DETECTOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TFD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tfd assertion failed");

// antecedent implies consequent in the following cycle
`define TFD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tfd assertion failed");

// antecedent implies a delayed consequent
`define TFD_ASSERT_TWO(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error("tfd assertion failed");

`endif

/* rtl/tfd_pkg.sv */
// ----------------------------------------------------------------------------
// tfd_pkg
// Constants, register codes and types shared by the fall detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tfd_pkg;

	// ring depth and sample width
	localparam int WINDOW      = 31;
	localparam int SAMPLE_BITS = 16;

	localparam int PTR_W   = $clog2(WINDOW);
	localparam int DIFF_W  = SAMPLE_BITS + 1;
	localparam int LIM_W   = 16;
	localparam int SIDE_W  = 15;
	localparam int CNT_W   = 5;
	// compare width: holds a differential, a limit and a negated side limit
	localparam int CMP_W   = ((DIFF_W > LIM_W) ? DIFF_W : LIM_W) + 1;

	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FWD_DIFF   = 3'd0,
		CFG_FWD_RATE   = 3'd1,
		CFG_BACK_ANGLE = 3'd2,
		CFG_BACK_DIFF  = 3'd3,
		CFG_BACK_RATE  = 3'd4,
		CFG_SIDE_DIFF  = 3'd5,
		CFG_SIDE_RATE  = 3'd6,
		CFG_DEBOUNCE   = 3'd7
	} cfg_idx_t;

	// reset values
	localparam logic signed [LIM_W-1:0] FWD_DIFF_RST   = -16'sd40;
	localparam logic signed [LIM_W-1:0] FWD_RATE_RST   = -16'sd480;
	localparam logic signed [LIM_W-1:0] BACK_ANGLE_RST = 16'sd480;
	localparam logic signed [LIM_W-1:0] BACK_DIFF_RST  = 16'sd64;
	localparam logic signed [LIM_W-1:0] BACK_RATE_RST  = 16'sd184;
	localparam logic [SIDE_W-1:0]       SIDE_DIFF_RST  = 15'd48;
	localparam logic [SIDE_W-1:0]       SIDE_RATE_RST  = 15'd440;
	localparam logic [CNT_W-1:0]        DEBOUNCE_RST   = 5'd16;

	// threshold set handed from the register file to the datapath
	typedef struct packed {
		logic signed [LIM_W-1:0] fwd_diff;
		logic signed [LIM_W-1:0] fwd_rate;
		logic signed [LIM_W-1:0] back_angle;
		logic signed [LIM_W-1:0] back_diff;
		logic signed [LIM_W-1:0] back_rate;
		logic [SIDE_W-1:0]       side_diff;
		logic [SIDE_W-1:0]       side_rate;
		logic [CNT_W-1:0]        debounce;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/tilt_fall_direction_detector.sv */
// Each input transfer passes the input register, then the result register.
// Throughput: one item per cycle while results are taken; a stalled result
// holds the input register, so the input stalls once both stages are full.
// Reset (arst_n low, asynchronous): rings and debounce counters clear to zero,
// the ring pointer to zero, thresholds return to defaults, both stages empty.
// ----------------------------------------------------------------------------
// tilt_fall_direction_detector
// Debounced forward/backward/left/right fall detection from orientation samples.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_fall_direction_detector (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration channel
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [tfd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [tfd_pkg::LIM_W-1:0]             cfg_data,
	// sample channel
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [tfd_pkg::SAMPLE_BITS-1:0] roll_angle,
	input  wire logic signed [tfd_pkg::SAMPLE_BITS-1:0] pitch_angle,
	input  wire logic signed [tfd_pkg::SAMPLE_BITS-1:0] rate_x,
	input  wire logic signed [tfd_pkg::SAMPLE_BITS-1:0] rate_y,
	// result channel
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [3:0]                                 fall_mask
);
	import tfd_pkg::*;

	cfg_t cfg;

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] roll_s1;
	logic signed [SAMPLE_BITS-1:0] pitch_s1;
	logic signed [SAMPLE_BITS-1:0] rate_x_s1;
	logic signed [SAMPLE_BITS-1:0] rate_y_s1;

	logic                          advance;
	logic signed [DIFF_W-1:0]      droll;
	logic signed [DIFF_W-1:0]      dpitch;

	logic signed [CMP_W-1:0] droll_c, dpitch_c, roll_c, rx_c, ry_c;
	logic signed [CMP_W-1:0] side_d_c, side_r_c;
	logic [3:0]              hit;
	logic [3:0]              reached;

	logic       out_valid_q;
	logic [3:0] fall_mask_q;

	// configuration: always ready
	assign cfg_ready = 1'b1;

	tfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage handshake
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			roll_s1   <= roll_angle;
			pitch_s1  <= pitch_angle;
			rate_x_s1 <= rate_x;
			rate_y_s1 <= rate_y;
		end
	end

	tfd_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.roll    (roll_s1),
		.pitch   (pitch_s1),
		.droll   (droll),
		.dpitch  (dpitch)
	);

	// threshold tests on sign-extended values
	assign droll_c  = CMP_W'(droll);
	assign dpitch_c = CMP_W'(dpitch);
	assign roll_c   = CMP_W'(roll_s1);
	assign rx_c     = CMP_W'(rate_x_s1);
	assign ry_c     = CMP_W'(rate_y_s1);
	assign side_d_c = CMP_W'({1'b0, cfg.side_diff});
	assign side_r_c = CMP_W'({1'b0, cfg.side_rate});

	assign hit[0] = (droll_c <= CMP_W'(cfg.fwd_diff)) && (rx_c <= CMP_W'(cfg.fwd_rate));
	assign hit[1] = (roll_c > CMP_W'(cfg.back_angle)) && (droll_c > CMP_W'(cfg.back_diff))
		&& (rx_c > CMP_W'(cfg.back_rate));
	assign hit[2] = (dpitch_c < -side_d_c) && (ry_c < -side_r_c);
	assign hit[3] = (dpitch_c > side_d_c) && (ry_c > side_r_c);

	// one debounce counter per direction
	for (genvar d = 0; d < 4; d++) begin : g_dir
		tfd_debounce u_deb (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.hit     (hit[d]),
			.limit   (cfg.debounce),
			.reached (reached[d])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			fall_mask_q <= reached;
	end

	assign out_valid = out_valid_q;
	assign fall_mask = fall_mask_q;

endmodule

`default_nettype wire

/* rtl/tfd_cfg.sv */
// ----------------------------------------------------------------------------
// tfd_cfg
// Threshold register file, written by transfers on the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tfd_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tfd_pkg::LIM_W-1:0]      cfg_data,
	output tfd_pkg::cfg_t                       cfg
);
	import tfd_pkg::*;

	cfg_t cfg_q;

	// register writes; every transfer is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fwd_diff   <= FWD_DIFF_RST;
			cfg_q.fwd_rate   <= FWD_RATE_RST;
			cfg_q.back_angle <= BACK_ANGLE_RST;
			cfg_q.back_diff  <= BACK_DIFF_RST;
			cfg_q.back_rate  <= BACK_RATE_RST;
			cfg_q.side_diff  <= SIDE_DIFF_RST;
			cfg_q.side_rate  <= SIDE_RATE_RST;
			cfg_q.debounce   <= DEBOUNCE_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FWD_DIFF:   cfg_q.fwd_diff   <= cfg_data;
				CFG_FWD_RATE:   cfg_q.fwd_rate   <= cfg_data;
				CFG_BACK_ANGLE: cfg_q.back_angle <= cfg_data;
				CFG_BACK_DIFF:  cfg_q.back_diff  <= cfg_data;
				CFG_BACK_RATE:  cfg_q.back_rate  <= cfg_data;
				CFG_SIDE_DIFF:  cfg_q.side_diff  <= cfg_data[SIDE_W-1:0];
				CFG_SIDE_RATE:  cfg_q.side_rate  <= cfg_data[SIDE_W-1:0];
				CFG_DEBOUNCE:   cfg_q.debounce   <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/tfd_ring.sv */
// ----------------------------------------------------------------------------
// tfd_ring
// Roll and pitch history rings; differential against the oldest entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tfd_ring (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  advance,
	input  wire logic signed [tfd_pkg::SAMPLE_BITS-1:0] roll,
	input  wire logic signed [tfd_pkg::SAMPLE_BITS-1:0] pitch,
	output logic signed [tfd_pkg::DIFF_W-1:0]          droll,
	output logic signed [tfd_pkg::DIFF_W-1:0]          dpitch
);
	import tfd_pkg::*;

	localparam logic [PTR_W-1:0] LAST = PTR_W'(WINDOW - 1);

	logic signed [SAMPLE_BITS-1:0] roll_ring_q  [WINDOW];
	logic signed [SAMPLE_BITS-1:0] pitch_ring_q [WINDOW];
	logic [PTR_W-1:0]              ptr_q;
	logic [PTR_W-1:0]              ptr_new;
	logic [PTR_W-1:0]              oldest;

	// write slot and oldest slot, both wrapping
	assign ptr_new = (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
	assign oldest  = (ptr_new == LAST) ? '0 : ptr_new + 1'b1;

	// oldest slot differs from the write slot, so the stored value is read
	assign droll  = DIFF_W'(roll)  - DIFF_W'(roll_ring_q[oldest]);
	assign dpitch = DIFF_W'(pitch) - DIFF_W'(pitch_ring_q[oldest]);

	// ring storage, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			for (int i = 0; i < WINDOW; i++) begin
				roll_ring_q[i]  <= '0;
				pitch_ring_q[i] <= '0;
			end
		end else if (advance) begin
			ptr_q                 <= ptr_new;
			roll_ring_q[ptr_new]  <= roll;
			pitch_ring_q[ptr_new] <= pitch;
		end
	end

endmodule

`default_nettype wire

/* rtl/tfd_debounce.sv */
// ----------------------------------------------------------------------------
// tfd_debounce
// Saturating up/down debounce counter with a reached flag for the next value.
// ----------------------------------------------------------------------------
`default_nettype none

module tfd_debounce (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       advance,
	input  wire logic                       hit,
	input  wire logic [tfd_pkg::CNT_W-1:0]  limit,
	output logic                            reached
);
	import tfd_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;

	// up while the test holds and below the limit, down to zero while it fails
	always_comb begin
		count_next = count_q;
		if (hit) begin
			if (count_q < limit)
				count_next = count_q + 1'b1;
		end else if (count_q != '0) begin
			count_next = count_q - 1'b1;
		end
	end

	assign reached = (count_next >= limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance) begin
			count_q <= count_next;
		end
	end

endmodule

`default_nettype wire

/* rtl/tfd_checker.sv */
// ----------------------------------------------------------------------------
// tfd_checker
// Port-level checks on the fall detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tilt_fall_direction_detector_defines.svh"

module tfd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cfg_valid,
	input wire logic       cfg_ready,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [3:0] fall_mask
);
	// a stalled result holds
	`TFD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(fall_mask))
	// an accepted sample is followed by a valid result after the input and result registers
	`TFD_ASSERT_TWO(a_in_to_out, in_valid && in_ready, out_valid)
	// with the result register empty the input side is never stalled
	`TFD_ASSERT_IMP(a_empty_ready, !out_valid, in_ready)
	// configuration writes are never back-pressured
	`TFD_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind tilt_fall_direction_detector tfd_checker u_tfd_checker (.*);

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: tilt fall direction detector testbench
// Drives orientation samples and threshold writes over valid/ready channels,
// predicts every fall mask with a local copy of the rings and debounce
// counters, and checks each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import tfd_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_SLACK     = 4;
	localparam int HOLD_CYCLES     = 200;
	localparam int SEGMENT_SAMPLES = 40;

	// threshold sets used by the random traffic
	typedef enum int {SET_DEFAULT, SET_TYPICAL, SET_WILD, SET_LOW, SET_HIGH} setting_kind_t;
	// shape of a roll or pitch trace inside a burst
	typedef enum int {RAMP_FLAT, RAMP_FALL, RAMP_RISE} ramp_t;

	logic                          clk;
	logic                          arst_n      = 1'b0;
	logic                          cfg_valid   = 1'b0;
	logic                          cfg_ready;
	cfg_idx_t                      cfg_index   = CFG_FWD_DIFF;
	logic [LIM_W-1:0]              cfg_data    = '0;
	logic                          in_valid    = 1'b0;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] roll_angle  = '0;
	logic signed [SAMPLE_BITS-1:0] pitch_angle = '0;
	logic signed [SAMPLE_BITS-1:0] rate_x      = '0;
	logic signed [SAMPLE_BITS-1:0] rate_y      = '0;
	logic                          out_valid;
	logic                          out_ready   = 1'b0;
	logic [3:0]                    fall_mask;

	// detector model state
	cfg_t                          thr_model;
	logic signed [SAMPLE_BITS-1:0] roll_hist [WINDOW];
	logic signed [SAMPLE_BITS-1:0] pitch_hist [WINDOW];
	int                            hist_ptr;
	logic [CNT_W-1:0]              fwd_cnt, back_cnt, left_cnt, right_cnt;
	logic [3:0]                    expected_masks [$];

	// threshold set last applied, used to steer the bursts
	cfg_t stim_thr;

	int samples_sent       = 0;
	int masks_checked      = 0;
	int mismatch_count     = 0;
	int input_stall_cycles = 0;
	int dir_reports [4]    = '{0, 0, 0, 0};
	int send_idle_pct      = 0;
	int recv_idle_pct      = 0;
	int hold_left          = 0;
	int cycle_count        = 0;
	bit hold_request       = 1'b0;

	tilt_fall_direction_detector i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.roll_angle  (roll_angle),
		.pitch_angle (pitch_angle),
		.rate_x      (rate_x),
		.rate_y      (rate_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.fall_mask   (fall_mask)
	);

	initial begin : clock_gen
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Model
	// ------------------------------------------------------------------

	// saturating up/down debounce counter
	function automatic logic [CNT_W-1:0] step_counter(logic [CNT_W-1:0] count, bit hit,
			logic [CNT_W-1:0] limit);
		if (hit) begin
			if (count < limit)
				return count + 1'b1;
			return count;
		end
		if (count != 0)
			return count - 1'b1;
		return count;
	endfunction

	// advance the rings and counters by one sample, return the fall mask
	function automatic logic [3:0] predict_fall_mask(logic signed [SAMPLE_BITS-1:0] roll,
			logic signed [SAMPLE_BITS-1:0] pitch, logic signed [SAMPLE_BITS-1:0] rx,
			logic signed [SAMPLE_BITS-1:0] ry);
		int oldest, r, p, x, y, d_roll, d_pitch;
		int f_diff, f_rate, b_angle, b_diff, b_rate, s_diff, s_rate;
		logic [CNT_W-1:0] lim;
		r       = roll;
		p       = pitch;
		x       = rx;
		y       = ry;
		f_diff  = $signed(thr_model.fwd_diff);
		f_rate  = $signed(thr_model.fwd_rate);
		b_angle = $signed(thr_model.back_angle);
		b_diff  = $signed(thr_model.back_diff);
		b_rate  = $signed(thr_model.back_rate);
		s_diff  = thr_model.side_diff;
		s_rate  = thr_model.side_rate;
		lim     = thr_model.debounce;

		// write the new sample, then look at the entry due to be overwritten next
		hist_ptr             = (hist_ptr + 1) % WINDOW;
		roll_hist[hist_ptr]  = roll;
		pitch_hist[hist_ptr] = pitch;
		oldest               = (hist_ptr + 1) % WINDOW;
		d_roll               = r - int'(roll_hist[oldest]);
		d_pitch              = p - int'(pitch_hist[oldest]);

		fwd_cnt   = step_counter(fwd_cnt, d_roll <= f_diff && x <= f_rate, lim);
		back_cnt  = step_counter(back_cnt,
			r > b_angle && d_roll > b_diff && x > b_rate, lim);
		left_cnt  = step_counter(left_cnt, d_pitch < -s_diff && y < -s_rate, lim);
		right_cnt = step_counter(right_cnt, d_pitch > s_diff && y > s_rate, lim);
		return {right_cnt >= lim, left_cnt >= lim, back_cnt >= lim, fwd_cnt >= lim};
	endfunction

	task automatic report_mismatch(input string msg);
		$display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// Transfer monitor: register writes, sample transfers, result checks
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		logic [3:0] expected_mask;
		if (!arst_n) begin
			thr_model.fwd_diff   = FWD_DIFF_RST;
			thr_model.fwd_rate   = FWD_RATE_RST;
			thr_model.back_angle = BACK_ANGLE_RST;
			thr_model.back_diff  = BACK_DIFF_RST;
			thr_model.back_rate  = BACK_RATE_RST;
			thr_model.side_diff  = SIDE_DIFF_RST;
			thr_model.side_rate  = SIDE_RATE_RST;
			thr_model.debounce   = DEBOUNCE_RST;
			for (int i = 0; i < WINDOW; i++) begin
				roll_hist[i]  = '0;
				pitch_hist[i] = '0;
			end
			hist_ptr  = 0;
			fwd_cnt   = '0;
			back_cnt  = '0;
			left_cnt  = '0;
			right_cnt = '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FWD_DIFF:   thr_model.fwd_diff   = cfg_data;
					CFG_FWD_RATE:   thr_model.fwd_rate   = cfg_data;
					CFG_BACK_ANGLE: thr_model.back_angle = cfg_data;
					CFG_BACK_DIFF:  thr_model.back_diff  = cfg_data;
					CFG_BACK_RATE:  thr_model.back_rate  = cfg_data;
					CFG_SIDE_DIFF:  thr_model.side_diff  = cfg_data[SIDE_W-1:0];
					CFG_SIDE_RATE:  thr_model.side_rate  = cfg_data[SIDE_W-1:0];
					CFG_DEBOUNCE:   thr_model.debounce   = cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_masks.push_back(predict_fall_mask(roll_angle, pitch_angle,
					rate_x, rate_y));
			if (in_valid && !in_ready)
				input_stall_cycles++;
			if (out_valid && out_ready) begin
				if (expected_masks.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending, fall_mask %h",
						fall_mask));
				end else begin
					expected_mask = expected_masks.pop_front();
					masks_checked++;
					if (fall_mask !== expected_mask)
						report_mismatch($sformatf("result %0d fall_mask %h, predicted %h",
							masks_checked, fall_mask, expected_mask));
					for (int b = 0; b < 4; b++)
						if (fall_mask[b] === 1'b1)
							dir_reports[b]++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: random idling plus requested hold-off stretches
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_receiver
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// uniform value in [lo, hi]; any sample value if the range is empty
	function automatic int rand_in(int lo, int hi);
		if (hi < lo)
			return int'($urandom_range(65535)) - 32768;
		return lo + int'($urandom_range(hi - lo));
	endfunction

	// one sample transfer, with a random idle gap in front of it
	task automatic send_sample(input int r, input int p, input int x, input int y);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		roll_angle  <= SAMPLE_BITS'(r);
		pitch_angle <= SAMPLE_BITS'(p);
		rate_x      <= SAMPLE_BITS'(x);
		rate_y      <= SAMPLE_BITS'(y);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		samples_sent++;
	endtask

	// stop offering samples and wait for every pending result
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_masks.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [LIM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// write a whole threshold set; unused upper data bits carry junk
	task automatic apply_thresholds(input setting_kind_t kind);
		cfg_t s;
		case (kind)
			SET_TYPICAL: begin
				s.fwd_diff   = LIM_W'(rand_in(-400, -10));
				s.fwd_rate   = LIM_W'(rand_in(-3000, -100));
				s.back_angle = LIM_W'(rand_in(-1000, 2000));
				s.back_diff  = LIM_W'(rand_in(10, 400));
				s.back_rate  = LIM_W'(rand_in(50, 3000));
				s.side_diff  = SIDE_W'(rand_in(0, 400));
				s.side_rate  = SIDE_W'(rand_in(0, 3000));
				s.debounce   = CNT_W'(rand_in(1, 31));
			end
			SET_WILD: begin
				s.fwd_diff   = LIM_W'($urandom);
				s.fwd_rate   = LIM_W'($urandom);
				s.back_angle = LIM_W'($urandom);
				s.back_diff  = LIM_W'($urandom);
				s.back_rate  = LIM_W'($urandom);
				s.side_diff  = SIDE_W'($urandom);
				s.side_rate  = SIDE_W'($urandom);
				s.debounce   = CNT_W'($urandom);
			end
			SET_LOW: begin
				s.fwd_diff   = 16'sh8000;
				s.fwd_rate   = 16'sh8000;
				s.back_angle = 16'sh8000;
				s.back_diff  = 16'sh8000;
				s.back_rate  = 16'sh8000;
				s.side_diff  = '0;
				s.side_rate  = '0;
				s.debounce   = CNT_W'(1);
			end
			SET_HIGH: begin
				s.fwd_diff   = 16'sh7FFF;
				s.fwd_rate   = 16'sh7FFF;
				s.back_angle = 16'sh7FFF;
				s.back_diff  = 16'sh7FFF;
				s.back_rate  = 16'sh7FFF;
				s.side_diff  = '1;
				s.side_rate  = '1;
				s.debounce   = '1;
			end
			default: begin
				s.fwd_diff   = FWD_DIFF_RST;
				s.fwd_rate   = FWD_RATE_RST;
				s.back_angle = BACK_ANGLE_RST;
				s.back_diff  = BACK_DIFF_RST;
				s.back_rate  = BACK_RATE_RST;
				s.side_diff  = SIDE_DIFF_RST;
				s.side_rate  = SIDE_RATE_RST;
				s.debounce   = DEBOUNCE_RST;
			end
		endcase
		pause_until_drained();
		write_reg(CFG_FWD_DIFF, s.fwd_diff);
		write_reg(CFG_FWD_RATE, s.fwd_rate);
		write_reg(CFG_BACK_ANGLE, s.back_angle);
		write_reg(CFG_BACK_DIFF, s.back_diff);
		write_reg(CFG_BACK_RATE, s.back_rate);
		write_reg(CFG_SIDE_DIFF, {1'($urandom), s.side_diff});
		write_reg(CFG_SIDE_RATE, {1'($urandom), s.side_rate});
		write_reg(CFG_DEBOUNCE, {11'($urandom), s.debounce});
		stim_thr = s;
	endtask

	// fully random sample, every bit free
	task automatic send_noise_sample();
		send_sample(rand_in(-32768, 32767), rand_in(-32768, 32767),
			rand_in(-32768, 32767), rand_in(-32768, 32767));
	endtask

	// a run of samples shaped like a fall: roll and/or pitch ramp while the
	// rates sit beyond their limits; the odd sample breaks the pattern
	task automatic send_fall_burst();
		ramp_t roll_dir, pitch_dir;
		int len, stride, r0, p0, r, p, x, y, k;
		int fwd_rate, back_angle, back_rate, side_rate;
		fwd_rate   = $signed(stim_thr.fwd_rate);
		back_angle = $signed(stim_thr.back_angle);
		back_rate  = $signed(stim_thr.back_rate);
		side_rate  = stim_thr.side_rate;
		roll_dir   = ramp_t'($urandom_range(2));
		pitch_dir  = ramp_t'($urandom_range(2));
		if (roll_dir == RAMP_FLAT && pitch_dir == RAMP_FLAT)
			roll_dir = ramp_t'(1 + $urandom_range(1));
		len    = $urandom_range(40, 8);
		stride = $urandom_range(150, 2);

		case (roll_dir)
			RAMP_FALL: r0 = rand_in(-32768 + len * stride, 32767);
			RAMP_RISE: r0 = rand_in(back_angle + 1, 32767 - len * stride);
			default:   r0 = rand_in(-4000, 4000);
		endcase
		case (pitch_dir)
			RAMP_FALL: p0 = rand_in(-32768 + len * stride, 32767);
			RAMP_RISE: p0 = rand_in(-32768, 32767 - len * stride);
			default:   p0 = rand_in(-4000, 4000);
		endcase

		for (k = 0; k < len; k++) begin
			case (roll_dir)
				RAMP_FALL: begin
					r = r0 - k * stride;
					x = rand_in(-32768, fwd_rate);
				end
				RAMP_RISE: begin
					r = r0 + k * stride;
					x = rand_in(back_rate + 1, 32767);
				end
				default: begin
					r = r0 + rand_in(-8, 8);
					x = rand_in(-32768, 32767);
				end
			endcase
			case (pitch_dir)
				RAMP_FALL: begin
					p = p0 - k * stride;
					y = rand_in(-32768, -side_rate - 1);
				end
				RAMP_RISE: begin
					p = p0 + k * stride;
					y = rand_in(side_rate + 1, 32767);
				end
				default: begin
					p = p0 + rand_in(-8, 8);
					y = rand_in(-32768, 32767);
				end
			endcase
			if ($urandom_range(11) == 0) begin
				x = rand_in(-32768, 32767);
				y = rand_in(-32768, 32767);
			end
			send_sample(r, p, x, y);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// field extremes and threshold boundaries while the rings still hold zeros
	task automatic test_field_extremes();
		send_sample(0, 0, 0, 0);
		send_sample(32767, 32767, 32767, 32767);
		send_sample(-32768, -32768, -32768, -32768);
		send_sample(-1, -1, -1, -1);
		send_sample(16'h5555, 16'h5555, 16'h5555, 16'h5555);
		send_sample(-21846, -21846, -21846, -21846);
		// forward exactly at both limits, then one step short
		send_sample(-40, 0, -480, 0);
		send_sample(-39, 0, -480, 0);
		// backward, left and right just beyond their limits
		send_sample(481, 0, 185, 0);
		send_sample(0, -49, 0, -441);
		send_sample(0, 49, 0, 441);
	endtask

	// a zero debounce limit reports every direction at once
	task automatic test_zero_debounce();
		pause_until_drained();
		write_reg(CFG_DEBOUNCE, 16'hFFE0);
		send_noise_sample();
		send_noise_sample();
		pause_until_drained();
		write_reg(CFG_DEBOUNCE, LIM_W'(DEBOUNCE_RST));
	endtask

	// limit lowered under a saturated counter: no count up, count down still works
	task automatic test_lowered_limit();
		pause_until_drained();
		write_reg(CFG_FWD_DIFF, 16'h7FFF);
		write_reg(CFG_FWD_RATE, '0);
		write_reg(CFG_DEBOUNCE, LIM_W'(5));
		repeat (6) send_sample(-32768, 0, -1, 0);
		pause_until_drained();
		write_reg(CFG_DEBOUNCE, LIM_W'(2));
		send_sample(-32768, 0, -1, 0);
		repeat (4) send_sample(-32768, 0, 1, 0);
	endtask

	// bursts and noise over three idling phases and a range of threshold sets
	task automatic test_random_traffic();
		setting_kind_t plan [12] = '{SET_DEFAULT, SET_TYPICAL, SET_HIGH, SET_TYPICAL,
			SET_WILD, SET_TYPICAL, SET_LOW, SET_TYPICAL,
			SET_DEFAULT, SET_TYPICAL, SET_WILD, SET_TYPICAL};
		int phase, seg, mark;
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 17; recv_idle_pct = 72; end
				1: begin send_idle_pct = 72; recv_idle_pct = 17; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (seg = 0; seg < 4; seg++) begin
				apply_thresholds(plan[phase * 4 + seg]);
				mark = samples_sent;
				while (samples_sent - mark < SEGMENT_SAMPLES) begin
					if ($urandom_range(99) < 80)
						send_fall_burst();
					else
						send_noise_sample();
				end
			end
		end
	endtask

	// long receiver hold-off while samples keep coming: input must stall
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		apply_thresholds(SET_TYPICAL);
		hold_request = 1'b1;
		repeat (3) send_fall_burst();
		pause_until_drained();
	endtask

	initial begin : test_sequence
		stim_thr.fwd_diff   = FWD_DIFF_RST;
		stim_thr.fwd_rate   = FWD_RATE_RST;
		stim_thr.back_angle = BACK_ANGLE_RST;
		stim_thr.back_diff  = BACK_DIFF_RST;
		stim_thr.back_rate  = BACK_RATE_RST;
		stim_thr.side_diff  = SIDE_DIFF_RST;
		stim_thr.side_rate  = SIDE_RATE_RST;
		stim_thr.debounce   = DEBOUNCE_RST;
		send_idle_pct = 17;
		recv_idle_pct = 72;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_zero_debounce();
		test_lowered_limit();
		test_random_traffic();
		test_backpressure();
		pause_until_drained();

		$display("tb: %0d samples, %0d results checked, %0d mismatches, %0d stalled input cycles",
			samples_sent, masks_checked, mismatch_count, input_stall_cycles);
		$display("tb: reported forward %0d, backward %0d, left %0d, right %0d",
			dir_reports[0], dir_reports[1], dir_reports[2], dir_reports[3]);
		if (mismatch_count == 0 && expected_masks.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// run limit
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: timeout after %0d cycles", cycle_count);
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl
rtl/tfd_pkg.sv
rtl/tfd_cfg.sv
rtl/tfd_ring.sv
rtl/tfd_debounce.sv
rtl/tilt_fall_direction_detector.sv
rtl/tfd_checker.sv
sim/tb_top.sv
